// ===== hdl/nsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nsd_pkg;

  // sentence geometry
  localparam int TERM_CHARS = 16;
  localparam int TERM_SLOTS = 32;

  // internal counter widths, sized to hold the limit itself
  localparam int LEN_W = $clog2(TERM_CHARS + 1);
  localparam int CNT_W = $clog2(TERM_SLOTS + 1);

  localparam logic [LEN_W-1:0] TERM_CHARS_L = LEN_W'(TERM_CHARS);
  localparam logic [CNT_W-1:0] TERM_SLOTS_L = CNT_W'(TERM_SLOTS);

  // fixed widths of the result word
  localparam int TERM_NUM_W = 5;
  localparam int CHAR_POS_W = 4;
  localparam int CLOSED_W   = 5;
  localparam int TOTAL_W    = 6;
  localparam int INCOMP_W   = 32;

  // character codes
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [3:0] HEX_TEN   = 4'd10;

  typedef struct packed {
    logic                  statement_valid;
    logic                  char_kept;
    logic [7:0]            char_out;
    logic [TERM_NUM_W-1:0] term_number;
    logic [CHAR_POS_W-1:0] char_position;
    logic                  term_closed;
    logic [CLOSED_W-1:0]   closed_length;
    logic                  checksum_checked;
    logic [7:0]            running_parity;
    logic [TOTAL_W-1:0]    terms_total;
    logic [INCOMP_W-1:0]   incomplete_count;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/nsd_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nsd_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_data_byte,
  output logic            in_stall,
  input  wire logic       advance,
  output logic            s1_valid,
  output logic [7:0]      s1_byte
);

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       load;

  // hold while the held word cannot move on
  assign in_stall     = s1_valid_r & ~advance;
  assign load         = in_valid & ~in_stall;
  assign s1_valid_nxt = load | (s1_valid_r & ~advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_byte_r <= in_data_byte;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_byte  = s1_byte_r;

endmodule

`default_nettype wire

// ===== hdl/nsd_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nsd_parse (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic [7:0] byte_in,
  output nsd_pkg::result_t res
);

  logic                      open_r, open_nxt;
  logic                      valid_r, valid_nxt;
  logic                      mode_r, mode_nxt;
  logic [7:0]                parity_r, parity_nxt;
  logic [nsd_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [nsd_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [7:0]                hex_r, hex_nxt;
  logic                      bad_r, bad_nxt;
  logic [31:0]               incomp_r, incomp_nxt;

  logic                      is_hex;
  logic [3:0]                digit;
  logic                      kept;
  logic [nsd_pkg::LEN_W-1:0] kept_pos;
  logic [nsd_pkg::CNT_W-1:0] kept_term;
  logic                      closed;
  logic [nsd_pkg::LEN_W-1:0] closed_len;
  logic                      checked;
  logic                      do_close;
  logic                      match;

  // hex digit decode
  always_comb begin
    is_hex = 1'b1;
    digit  = 4'd0;
    if (byte_in >= nsd_pkg::CH_UPPER_A && byte_in <= nsd_pkg::CH_UPPER_F) begin
      digit = 4'(byte_in - nsd_pkg::CH_UPPER_A) + nsd_pkg::HEX_TEN;
    end else if (byte_in >= nsd_pkg::CH_LOWER_A && byte_in <= nsd_pkg::CH_LOWER_F) begin
      digit = 4'(byte_in - nsd_pkg::CH_LOWER_A) + nsd_pkg::HEX_TEN;
    end else if (byte_in >= nsd_pkg::CH_ZERO && byte_in <= nsd_pkg::CH_NINE) begin
      digit = 4'(byte_in - nsd_pkg::CH_ZERO);
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    open_nxt   = open_r;
    valid_nxt  = valid_r;
    mode_nxt   = mode_r;
    parity_nxt = parity_r;
    len_nxt    = len_r;
    count_nxt  = count_r;
    hex_nxt    = hex_r;
    bad_nxt    = bad_r;
    incomp_nxt = incomp_r;
    kept       = 1'b0;
    kept_pos   = '0;
    kept_term  = '0;
    closed     = 1'b0;
    closed_len = '0;
    checked    = 1'b0;
    do_close   = 1'b0;
    match      = 1'b0;

    case (byte_in)
      nsd_pkg::CH_COMMA: begin
        parity_nxt = parity_r ^ byte_in;
        do_close   = 1'b1;
      end
      nsd_pkg::CH_STAR: begin
        do_close = 1'b1;
        mode_nxt = 1'b1;
      end
      nsd_pkg::CH_CR, nsd_pkg::CH_LF: begin
        do_close = 1'b1;
      end
      nsd_pkg::CH_DOLLAR: begin
        len_nxt    = '0;
        count_nxt  = '0;
        parity_nxt = 8'd0;
        mode_nxt   = 1'b0;
        valid_nxt  = 1'b0;
        hex_nxt    = 8'd0;
        bad_nxt    = 1'b0;
        if (open_r) begin
          incomp_nxt = incomp_r + 32'd1;
        end
        open_nxt = 1'b1;
      end
      default: begin
        if (len_r < nsd_pkg::TERM_CHARS_L) begin
          if (!is_hex || hex_r[7:4] != 4'd0) begin
            bad_nxt = 1'b1;
          end
          hex_nxt = {hex_r[3:0], digit};
          if (open_r && count_r < nsd_pkg::TERM_SLOTS_L) begin
            kept      = 1'b1;
            kept_term = count_r;
            kept_pos  = len_r;
          end
          len_nxt = len_r + nsd_pkg::LEN_W'(1);
        end
        if (!mode_r) begin
          parity_nxt = parity_r ^ byte_in;
        end
      end
    endcase

    // term close, compare uses parity after a comma
    if (do_close) begin
      if (open_r) begin
        if (count_r < nsd_pkg::TERM_SLOTS_L) begin
          count_nxt  = count_r + nsd_pkg::CNT_W'(1);
          closed     = 1'b1;
          closed_len = len_r;
        end
        if (mode_r) begin
          checked   = 1'b1;
          match     = ~bad_r & (hex_r == parity_nxt);
          valid_nxt = match;
          open_nxt  = ~match;
        end
        len_nxt = '0;
        hex_nxt = 8'd0;
        bad_nxt = 1'b0;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r   <= 1'b0;
      valid_r  <= 1'b0;
      mode_r   <= 1'b0;
      parity_r <= 8'd0;
      len_r    <= '0;
      count_r  <= '0;
      hex_r    <= 8'd0;
      bad_r    <= 1'b0;
      incomp_r <= 32'd0;
    end else if (step_en) begin
      open_r   <= open_nxt;
      valid_r  <= valid_nxt;
      mode_r   <= mode_nxt;
      parity_r <= parity_nxt;
      len_r    <= len_nxt;
      count_r  <= count_nxt;
      hex_r    <= hex_nxt;
      bad_r    <= bad_nxt;
      incomp_r <= incomp_nxt;
    end
  end

  always_comb begin
    res.statement_valid  = valid_nxt;
    res.char_kept        = kept;
    res.char_out         = byte_in;
    res.term_number      = nsd_pkg::TERM_NUM_W'(kept_term);
    res.char_position    = nsd_pkg::CHAR_POS_W'(kept_pos);
    res.term_closed      = closed;
    res.closed_length    = nsd_pkg::CLOSED_W'(closed_len);
    res.checksum_checked = checked;
    res.running_parity   = parity_nxt;
    res.terms_total      = nsd_pkg::TOTAL_W'(count_nxt);
    res.incomplete_count = incomp_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/nmea_sentence_deframer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake          | payload
// in_     | in        | in_valid/in_stall  | in_data_byte
// out_    | out       | out_valid/out_stall| statement_valid .. incomplete_count
//
// one byte per cycle sustained while out_stall is low; an accepted byte loads
// the input register, then moves through the parse step into the result
// register once it can advance, and out_ shows it from that register
// the per-byte state update is a combinational loop around the parse stage registers
// synchronous active-low reset clears all sentence state and both valids
// out_stall backs up through the result register into in_stall the same cycle

module nmea_sentence_deframer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_statement_valid,
  output logic             out_char_kept,
  output logic [7:0]       out_char_out,
  output logic [4:0]       out_term_number,
  output logic [3:0]       out_char_position,
  output logic             out_term_closed,
  output logic [4:0]       out_closed_length,
  output logic             out_checksum_checked,
  output logic [7:0]       out_running_parity,
  output logic [5:0]       out_terms_total,
  output logic [31:0]      out_incomplete_count
);

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             advance;
  nsd_pkg::result_t step_res;

  // result register
  logic             out_valid_r;
  logic             out_valid_nxt;
  nsd_pkg::result_t res_r;

  // the held byte moves on when the result register is free or draining
  assign advance = s1_valid & (~out_valid_r | ~out_stall);

  nsd_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_stall     (in_stall),
    .advance      (advance),
    .s1_valid     (s1_valid),
    .s1_byte      (s1_byte)
  );

  // parse state commits only on the cycle the word moves forward
  nsd_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .byte_in (s1_byte),
    .res     (step_res)
  );

  assign out_valid_nxt = advance | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= step_res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_statement_valid  = res_r.statement_valid;
  assign out_char_kept        = res_r.char_kept;
  assign out_char_out         = res_r.char_out;
  assign out_term_number      = res_r.term_number;
  assign out_char_position    = res_r.char_position;
  assign out_term_closed      = res_r.term_closed;
  assign out_closed_length    = res_r.closed_length;
  assign out_checksum_checked = res_r.checksum_checked;
  assign out_running_parity   = res_r.running_parity;
  assign out_terms_total      = res_r.terms_total;
  assign out_incomplete_count = res_r.incomplete_count;

endmodule

`default_nettype wire

// ===== test/nmea_sentence_deframer_checker.sv =====
`timescale 1ns / 1ps

module nmea_sentence_deframer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_statement_valid,
  input  logic        out_char_kept,
  input  logic [7:0]  out_char_out,
  input  logic [4:0]  out_term_number,
  input  logic [3:0]  out_char_position,
  input  logic        out_term_closed,
  input  logic [4:0]  out_closed_length,
  input  logic        out_checksum_checked,
  input  logic [7:0]  out_running_parity,
  input  logic [5:0]  out_terms_total,
  input  logic [31:0] out_incomplete_count,
  output int          outstanding,
  output int          fail_count
);
  import nsd_pkg::*;

  // parser state as seen after the last accepted word
  logic        sent_open;
  logic        sent_valid;
  logic        cks_mode;
  logic        hex_bad;
  logic [7:0]  parity;
  logic [7:0]  hex_val;
  int          char_cnt;
  int          term_cnt;
  logic [31:0] reopen_total;

  // per-word side results of a term close
  logic        now_closed;
  logic [4:0]  now_len;
  logic        now_checked;

  result_t     predicted_q[$];
  int          mismatches = 0;
  int          words_seen = 0;

  assign fail_count = mismatches;

  function automatic void end_term();
    if (sent_open) begin
      if (term_cnt < TERM_SLOTS) begin
        term_cnt++;
        now_closed = 1'b1;
        now_len = 5'(char_cnt);
      end
      if (cks_mode) begin
        now_checked = 1'b1;
        sent_valid = !hex_bad && (hex_val == parity);
        sent_open = !sent_valid;
      end
      char_cnt = 0;
      hex_val = '0;
      hex_bad = 1'b0;
    end else begin
      sent_valid = 1'b0;
    end
  endfunction

  function automatic result_t deframe_byte(input logic [7:0] c);
    result_t    r;
    logic [3:0] digit;
    logic       is_hex;
    r = '0;
    now_closed = 1'b0;
    now_len = '0;
    now_checked = 1'b0;
    if (c == CH_COMMA) begin
      parity ^= c;
      end_term();
    end else if (c == CH_STAR) begin
      end_term();
      cks_mode = 1'b1;
    end else if (c == CH_CR || c == CH_LF) begin
      end_term();
    end else if (c == CH_DOLLAR) begin
      char_cnt = 0;
      term_cnt = 0;
      parity = '0;
      cks_mode = 1'b0;
      sent_valid = 1'b0;
      hex_val = '0;
      hex_bad = 1'b0;
      if (sent_open) reopen_total++;
      sent_open = 1'b1;
    end else begin
      // overlong terms drop the byte but still fold it into the parity outside the checksum field
      if (char_cnt < TERM_CHARS) begin
        is_hex = 1'b1;
        if (c >= CH_UPPER_A && c <= CH_UPPER_F) digit = 4'(c - CH_UPPER_A) + HEX_TEN;
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F) digit = 4'(c - CH_LOWER_A) + HEX_TEN;
        else if (c >= CH_ZERO && c <= CH_NINE) digit = 4'(c - CH_ZERO);
        else begin
          digit = '0;
          is_hex = 1'b0;
        end
        if (!is_hex || hex_val[7:4] != 4'd0) hex_bad = 1'b1;
        hex_val = {hex_val[3:0], digit};
        if (sent_open && term_cnt < TERM_SLOTS) begin
          r.char_kept = 1'b1;
          r.term_number = 5'(term_cnt);
          r.char_position = 4'(char_cnt);
        end
        char_cnt++;
      end
      if (!cks_mode) parity ^= c;
    end
    r.statement_valid = sent_valid;
    r.char_out = c;
    r.term_closed = now_closed;
    r.closed_length = now_len;
    r.checksum_checked = now_checked;
    r.running_parity = parity;
    r.terms_total = 6'(term_cnt);
    r.incomplete_count = reopen_total;
    return r;
  endfunction

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("deframer mismatch at word %0d: %s got 0x%0h, predicted 0x%0h",
             words_seen, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      sent_open = 1'b0;
      sent_valid = 1'b0;
      cks_mode = 1'b0;
      hex_bad = 1'b0;
      parity = '0;
      hex_val = '0;
      char_cnt = 0;
      term_cnt = 0;
      reopen_total = '0;
      predicted_q.delete();
      outstanding <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_q.size() == 0) begin
          report("unexpected word", out_char_out, 0);
        end else begin
          want = predicted_q.pop_front();
          if (out_statement_valid !== want.statement_valid)
            report("statement_valid", out_statement_valid, want.statement_valid);
          if (out_char_kept !== want.char_kept)
            report("char_kept", out_char_kept, want.char_kept);
          if (out_char_out !== want.char_out)
            report("char_out", out_char_out, want.char_out);
          if (out_term_number !== want.term_number)
            report("term_number", out_term_number, want.term_number);
          if (out_char_position !== want.char_position)
            report("char_position", out_char_position, want.char_position);
          if (out_term_closed !== want.term_closed)
            report("term_closed", out_term_closed, want.term_closed);
          if (out_closed_length !== want.closed_length)
            report("closed_length", out_closed_length, want.closed_length);
          if (out_checksum_checked !== want.checksum_checked)
            report("checksum_checked", out_checksum_checked, want.checksum_checked);
          if (out_running_parity !== want.running_parity)
            report("running_parity", out_running_parity, want.running_parity);
          if (out_terms_total !== want.terms_total)
            report("terms_total", out_terms_total, want.terms_total);
          if (out_incomplete_count !== want.incomplete_count)
            report("incomplete_count", out_incomplete_count, want.incomplete_count);
        end
        words_seen++;
      end
      if (in_valid && !in_stall) predicted_q.push_back(deframe_byte(in_data_byte));
      outstanding <= predicted_q.size();
    end
  end

endmodule

// ===== test/nmea_sentence_deframer_core_tb.sv =====
`timescale 1ns / 1ps

module nmea_sentence_deframer_core_tb;
  import nsd_pkg::*;

  // run shape
  localparam int ITEM_TARGET = 1700;   // words offered before the end
  localparam int TAIL_AT     = 1500;   // from here on no idling on either side
  localparam int HOLD_AT     = 1200;   // cycle at which the long receiver hold starts
  localparam int HOLD_LEN    = 120;    // length of that hold in cycles
  localparam int DRAIN_WAIT  = 8;      // extra wait once the checker has no word outstanding
  localparam int CYCLE_LIMIT = 400000;

  // ways a random sentence can end its checksum field
  typedef enum int {
    CK_GOOD, CK_LEADING_ZERO, CK_LOWER, CK_WRONG, CK_NON_HEX,
    CK_EMPTY, CK_WIDE, CK_DOUBLE_STAR, CK_MISSING
  } cks_kind_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_statement_valid;
  logic        out_char_kept;
  logic [7:0]  out_char_out;
  logic [4:0]  out_term_number;
  logic [3:0]  out_char_position;
  logic        out_term_closed;
  logic [4:0]  out_closed_length;
  logic        out_checksum_checked;
  logic [7:0]  out_running_parity;
  logic [5:0]  out_terms_total;
  logic [31:0] out_incomplete_count;

  int          outstanding;
  int          fail_count;

  // shared stimulus knobs
  logic        tail = 1'b0;      // set once the quiet last part begins
  int          tx_mode = 0;      // sender idle density: 0 none, 1 light, 2 heavy
  int          items_sent = 0;
  int          cycles = 0;

  // receiver side state
  int          rx_cycles = 0;
  int          rx_hold = 0;
  int          rx_burst = 0;
  int          rx_mode = 0;

  always #5 clk = ~clk;

  nmea_sentence_deframer_core u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_statement_valid  (out_statement_valid),
    .out_char_kept        (out_char_kept),
    .out_char_out         (out_char_out),
    .out_term_number      (out_term_number),
    .out_char_position    (out_char_position),
    .out_term_closed      (out_term_closed),
    .out_closed_length    (out_closed_length),
    .out_checksum_checked (out_checksum_checked),
    .out_running_parity   (out_running_parity),
    .out_terms_total      (out_terms_total),
    .out_incomplete_count (out_incomplete_count)
  );

  nmea_sentence_deframer_checker u_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_statement_valid  (out_statement_valid),
    .out_char_kept        (out_char_kept),
    .out_char_out         (out_char_out),
    .out_term_number      (out_term_number),
    .out_char_position    (out_char_position),
    .out_term_closed      (out_term_closed),
    .out_closed_length    (out_closed_length),
    .out_checksum_checked (out_checksum_checked),
    .out_running_parity   (out_running_parity),
    .out_terms_total      (out_terms_total),
    .out_incomplete_count (out_incomplete_count),
    .outstanding          (outstanding),
    .fail_count           (fail_count)
  );

  // watchdog: a hung handshake or a lost word ends here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("nmea_sentence_deframer_core_tb: FAIL");
      $finish;
    end
  end

  // receiver: random stall bursts, with a density picked anew whenever rx_cycles[7:0] is zero,
  // one long hold so the pipe backs up into in_stall, and no stalls in the tail
  always @(posedge clk) begin
    rx_cycles <= rx_cycles + 1;
    if (rx_cycles[7:0] == 8'd0) rx_mode <= $urandom_range(0, 2);
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (rx_hold != 0) begin
      out_stall <= 1'b1;
      rx_hold <= rx_hold - 1;
    end else if (rx_cycles == HOLD_AT) begin
      out_stall <= 1'b1;
      rx_hold <= HOLD_LEN - 1;
    end else if (tail) begin
      out_stall <= 1'b0;
    end else if (rx_burst != 0) begin
      out_stall <= 1'b1;
      rx_burst <= rx_burst - 1;
    end else if (rx_mode != 0 && $urandom_range(0, (rx_mode == 1) ? 9 : 2) == 0) begin
      out_stall <= 1'b1;
      rx_burst <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // characters that would end or open a term
  function automatic logic is_framing(input logic [7:0] c);
    return c == CH_COMMA || c == CH_STAR || c == CH_DOLLAR || c == CH_CR || c == CH_LF;
  endfunction

  // term payload: mostly printable, sometimes any byte that is not a framing character
  function automatic logic [7:0] field_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(0, 255));
      else c = 8'($urandom_range(8'h20, 8'h7E));
    end while (is_framing(c));
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic lower);
    if (nib < HEX_TEN) return CH_ZERO + 8'(nib);
    return (lower ? CH_LOWER_A : CH_UPPER_A) + 8'(nib - HEX_TEN);
  endfunction

  // offer one word and hold it until accepted; an idle gap may come first
  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (!tail && tx_mode != 0 && $urandom_range(0, (tx_mode == 1) ? 9 : 2) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (items_sent >= TAIL_AT) tail <= 1'b1;
  endtask

  task automatic push_hex2(input logic [7:0] v, input logic lower);
    push_byte(hex_char(v[7:4], lower));
    push_byte(hex_char(v[3:0], lower));
  endtask

  // one random sentence; most are well formed, some carry a broken checksum or end
  task automatic send_sentence();
    logic [7:0] par;
    logic [7:0] c;
    int         nterms;
    int         len;
    int         ending;
    cks_kind_e  kind;
    par = '0;
    // occasionally enough terms to run out of slots
    if ($urandom_range(0, 11) == 0) nterms = $urandom_range(TERM_SLOTS - 2, TERM_SLOTS + 4);
    else nterms = $urandom_range(0, 8);
    push_byte(CH_DOLLAR);
    for (int t = 0; t < nterms; t++) begin
      if (t > 0) begin
        push_byte(CH_COMMA);
        par ^= CH_COMMA;
      end
      // occasionally a term longer than the character limit
      if ($urandom_range(0, 14) == 0) len = $urandom_range(TERM_CHARS - 2, TERM_CHARS + 4);
      else len = $urandom_range(0, 6);
      for (int i = 0; i < len; i++) begin
        c = field_char();
        push_byte(c);
        par ^= c;
      end
    end
    if ($urandom_range(0, 1) == 0) kind = CK_GOOD;
    else kind = cks_kind_e'($urandom_range(CK_GOOD, CK_MISSING));
    if (kind == CK_MISSING) return;  // truncated, the next '$' counts it incomplete
    push_byte(CH_STAR);
    case (kind)
      CK_GOOD:         push_hex2(par, 1'b0);
      CK_LOWER:        push_hex2(par, 1'b1);
      CK_LEADING_ZERO: begin
        push_byte(CH_ZERO);
        push_hex2(par, 1'b0);
      end
      CK_WRONG:        push_hex2(par ^ 8'($urandom_range(1, 255)), 1'b0);
      CK_NON_HEX: begin
        push_byte(hex_char(par[7:4], 1'b0));
        push_byte(8'($urandom_range(8'h47, 8'h5A)));
      end
      CK_WIDE: begin
        // three significant digits overflow eight bits
        push_byte(hex_char(4'($urandom_range(1, 15)), 1'b0));
        push_hex2(par, 1'b0);
      end
      CK_DOUBLE_STAR: begin
        push_hex2(par, 1'b0);
        push_byte(CH_STAR);
      end
      default: ;  // empty checksum field
    endcase
    ending = $urandom_range(0, 3);
    if (ending <= 1) begin
      push_byte(CH_CR);
      push_byte(CH_LF);
    end else if (ending == 2) begin
      push_byte(CH_LF);
    end
  endtask

  initial begin
    logic [7:0] par;
    int         noise_len;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: bytes with no sentence open, including a lone terminator
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_LF);
    // clean sentence with upper and lower case letters and a matching checksum
    par = "a" ^ CH_COMMA ^ "F" ^ "9";
    push_byte(CH_DOLLAR);
    push_byte("a");
    push_byte(CH_COMMA);
    push_byte("F");
    push_byte("9");
    push_byte(CH_STAR);
    push_hex2(par, 1'b0);
    push_byte(CH_CR);
    push_byte(CH_LF);
    // non-hex checksum digit, then a second star compares again
    push_byte(CH_DOLLAR);
    push_byte(CH_ZERO);
    push_byte(CH_STAR);
    push_byte("Z");
    push_byte(CH_STAR);
    push_byte(CH_LF);
    // reopen while open, then an empty checksum against zero parity
    push_byte(CH_DOLLAR);
    push_byte(CH_DOLLAR);
    push_byte(CH_STAR);
    push_byte(CH_CR);

    // random part: mostly sentences, some raw noise in between
    while (items_sent < ITEM_TARGET) begin
      tx_mode = $urandom_range(0, 2);
      if ($urandom_range(0, 6) == 0) begin
        noise_len = $urandom_range(1, 8);
        for (int i = 0; i < noise_len; i++) push_byte(8'($urandom_range(0, 255)));
      end else begin
        send_sentence();
      end
    end
    in_valid <= 1'b0;

    // drain: every predicted word must come back
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("nmea_sentence_deframer_core_tb: PASS");
    end else begin
      $display("nmea_sentence_deframer_core_tb: FAIL");
    end
    $finish;
  end

endmodule
